FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the AT command interpreter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/atci_pkg.sv
// ---------------------------------------------------------------------------
// atci_pkg
// Shared types, character codes and constant tables of the AT interpreter.
// ---------------------------------------------------------------------------
package atci_pkg;

  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Text table layout
  localparam logic [5:0] ROM_I_START    = 6'd0;
  localparam logic [5:0] ROM_I_NV_START = 6'd2;
  localparam logic [5:0] ROM_I_END      = 6'd20;
  localparam logic [5:0] ROM_OK_START   = 6'd21;
  localparam logic [5:0] ROM_OK_END     = 6'd26;
  localparam logic [5:0] ROM_CON_START  = 6'd27;
  localparam logic [5:0] ROM_CON_END    = 6'd37;
  localparam logic [5:0] ROM_ERR_START  = 6'd38;
  localparam logic [5:0] ROM_ERR_END    = 6'd46;

  typedef struct packed {
    logic       begin_item;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_port;
    logic       line_clear;
    logic       line_push;
    logic       line_rd;
    logic [7:0] line_addr;
    logic       s_rd;
    logic       s_wr;
    logic       s_clear;
    logic [7:0] s_addr;
    logic [7:0] s_wdata;
    logic       drain_rd;
    logic       drain_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] line_rdata;
    logic [7:0] line_count;
    logic       line_reject;
    logic [7:0] s_rdata;
    logic       ob_empty;
    logic       drain_last;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic       show_h;
    logic       show_t;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
  } dec_t;

  function automatic logic [7:0] rom_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0, 6'd19, 6'd21, 6'd25, 6'd27, 6'd36, 6'd38, 6'd45: b = CH_CR;
      6'd1, 6'd20, 6'd22, 6'd26, 6'd28, 6'd37, 6'd39, 6'd46: b = CH_LF;
      6'd2:  b = 8'd97;
      6'd3:  b = 8'd116;
      6'd4:  b = 8'd45;
      6'd5:  b = 8'd109;
      6'd6:  b = 8'd111;
      6'd7:  b = 8'd100;
      6'd8:  b = 8'd101;
      6'd9:  b = 8'd109;
      6'd10: b = 8'd45;
      6'd11: b = 8'd101;
      6'd12: b = 8'd109;
      6'd13: b = 8'd117;
      6'd14: b = 8'd108;
      6'd15: b = 8'd97;
      6'd16: b = 8'd116;
      6'd17: b = 8'd111;
      6'd18: b = 8'd114;
      6'd23: b = "O";
      6'd24: b = "K";
      6'd29: b = "C";
      6'd30: b = "O";
      6'd31: b = "N";
      6'd32: b = "N";
      6'd33: b = "E";
      6'd34: b = "C";
      6'd35: b = "T";
      6'd40: b = "E";
      6'd41: b = "R";
      6'd42: b = "R";
      6'd43: b = "O";
      6'd44: b = "R";
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] s_default(input logic [7:0] idx);
    logic [7:0] v;
    case (idx)
      8'd2:  v = 8'd43;
      8'd3:  v = 8'd13;
      8'd4:  v = 8'd10;
      8'd5:  v = 8'd8;
      8'd6:  v = 8'd2;
      8'd7:  v = 8'd50;
      8'd8:  v = 8'd2;
      8'd9:  v = 8'd6;
      8'd10: v = 8'd14;
      8'd11: v = 8'd95;
      8'd12: v = 8'd50;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_dial(input logic [7:0] c);
    return is_digit(c) || c == "t" || c == "T" || c == "p" || c == "P" || c == "*" ||
           c == "#" || c == "+" || ((c >= "A") && (c <= "D")) ||
           ((c >= "a") && (c <= "d")) || c == "," || c == "!" || c == "W" ||
           c == "w" || c == "@";
  endfunction

  // v*10 + digit, saturated at 999
  function automatic logic [9:0] accumulate(input logic [9:0] v, input logic [7:0] c);
    logic [13:0] t;
    logic [7:0]  d;
    d = c - CH_ZERO;
    t = {v, 3'b000} + {3'b000, v, 1'b0} + {10'd0, d[3:0]};
    return (t > 14'd999) ? 10'd999 : t[9:0];
  endfunction

  // Decimal digits of a byte; tens by reciprocal multiply (exact below 100)
  function automatic dec_t decimal(input logic [7:0] v);
    dec_t        d;
    logic [7:0]  r;
    logic [14:0] p;
    logic [7:0]  tt;
    if (v >= 8'd200) begin
      d.h = 4'd2;
      r   = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.h = 4'd1;
      r   = v - 8'd100;
    end else begin
      d.h = 4'd0;
      r   = v;
    end
    p      = {7'd0, r} * 15'd205;
    d.t    = {1'b0, p[13:11]} | {p[14], 3'b000};
    tt     = {4'd0, d.t};
    d.o    = 4'(r - ((tt << 3) + (tt << 1)));
    d.show_h = (v >= 8'd100);
    d.show_t = (v >= 8'd10);
    return d;
  endfunction

endpackage

FILE: rtl/atci_dp.sv
// ---------------------------------------------------------------------------
// atci_dp
// Datapath: input byte, line buffer, S registers, response buffer and the
// output register that streams the response.
// ---------------------------------------------------------------------------
module atci_dp #(
  parameter int LINE_DEPTH    = 40,
  parameter int S_REG_COUNT   = 13,
  parameter int MAX_OUT_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  atci_pkg::dp_cmd_t  cmd,
  output atci_pkg::dp_stat_t st,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_port,
  output logic               last,
  output logic               truncated
);
  import atci_pkg::*;

  localparam int LW  = $clog2(LINE_DEPTH);
  localparam int CW  = $clog2(LINE_DEPTH + 1);
  localparam int SW  = (S_REG_COUNT > 1) ? $clog2(S_REG_COUNT) : 1;
  localparam int OIW = $clog2(MAX_OUT_BYTES);
  localparam int OW  = $clog2(MAX_OUT_BYTES + 1);

  logic [7:0]             rx_q;
  logic [7:0]             line_mem [LINE_DEPTH];
  logic [CW-1:0]          line_count;
  logic                   line_reject;
  logic [7:0]             line_q;
  logic [7:0]             s_mem [S_REG_COUNT];
  logic [S_REG_COUNT-1:0] s_valid;
  logic [7:0]             s_q;
  logic                   s_qv;
  logic [7:0]             s_qdef;
  logic [8:0]             ob_mem [MAX_OUT_BYTES];
  logic [OW-1:0]          ob_n;
  logic                   ob_trunc;
  logic [OIW-1:0]         dr_ptr;
  logic [8:0]             ob_q;
  logic                   out_free;
  logic                   drain_last;

  assign out_free   = !out_valid || !out_stall;
  assign drain_last = (OW'(dr_ptr) == (ob_n - OW'(1)));

  always_ff @(posedge clk) begin
    if (cmd.begin_item) begin
      rx_q <= rx_byte;
    end
  end

  // Line buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      line_reject <= 1'b0;
    end else if (cmd.line_clear) begin
      line_count  <= '0;
      line_reject <= 1'b0;
    end else if (cmd.line_push) begin
      if (line_count < CW'(LINE_DEPTH)) begin
        line_count <= line_count + CW'(1);
      end else begin
        line_reject <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line_push && (line_count < CW'(LINE_DEPTH))) begin
      line_mem[line_count[LW-1:0]] <= rx_q;
    end
    if (cmd.line_rd) begin
      line_q <= line_mem[cmd.line_addr[LW-1:0]];
    end
  end

  // S registers; an entry with a clear valid bit reads its default
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else if (cmd.s_clear) begin
      s_valid <= '0;
    end else if (cmd.s_wr) begin
      s_valid[cmd.s_addr[SW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s_wr) begin
      s_mem[cmd.s_addr[SW-1:0]] <= cmd.s_wdata;
    end
    if (cmd.s_rd) begin
      s_q    <= s_mem[cmd.s_addr[SW-1:0]];
      s_qv   <= s_valid[cmd.s_addr[SW-1:0]];
      s_qdef <= s_default(cmd.s_addr);
    end
  end

  // Response buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_n     <= '0;
      ob_trunc <= 1'b0;
      dr_ptr   <= '0;
    end else if (cmd.begin_item) begin
      ob_n     <= '0;
      ob_trunc <= 1'b0;
      dr_ptr   <= '0;
    end else begin
      if (cmd.emit) begin
        if (ob_n < OW'(MAX_OUT_BYTES)) begin
          ob_n <= ob_n + OW'(1);
        end else begin
          ob_trunc <= 1'b1;
        end
      end
      if (cmd.drain_load) begin
        dr_ptr <= dr_ptr + OIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && (ob_n < OW'(MAX_OUT_BYTES))) begin
      ob_mem[ob_n[OIW-1:0]] <= {cmd.emit_port, cmd.emit_byte};
    end
    if (cmd.drain_rd) begin
      ob_q <= ob_mem[dr_ptr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.drain_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      out_byte  <= ob_q[7:0];
      out_port  <= ob_q[8];
      last      <= drain_last;
      truncated <= ob_trunc;
    end
  end

  always_comb begin
    st.rx_byte     = rx_q;
    st.line_rdata  = line_q;
    st.line_count  = 8'(line_count);
    st.line_reject = line_reject;
    st.s_rdata     = s_qv ? s_q : s_qdef;
    st.ob_empty    = (ob_n == '0);
    st.drain_last  = drain_last;
    st.out_free    = out_free;
  end

endmodule

FILE: rtl/atci_ctrl.sv
// ---------------------------------------------------------------------------
// atci_ctrl
// Controller: mode tracking, line scan and command execution sequencing.
// ---------------------------------------------------------------------------
module atci_ctrl #(
  parameter int LINE_DEPTH  = 40,
  parameter int S_REG_COUNT = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output atci_pkg::dp_cmd_t  cmd,
  input  atci_pkg::dp_stat_t st
);
  import atci_pkg::*;

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [10:0] SCNT = 11'(S_REG_COUNT);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_FRONT    = 18'h00002,
    S_PLUS_B   = 18'h00004,
    S_TAIL_B   = 18'h00008,
    S_PARSE_RD = 18'h00010,
    S_PARSE_EX = 18'h00020,
    S_EXEC     = 18'h00040,
    S_ROM      = 18'h00080,
    S_DIG_H    = 18'h00100,
    S_DIG_T    = 18'h00200,
    S_DIG_O    = 18'h00400,
    S_CONT     = 18'h00800,
    S_RESULT   = 18'h01000,
    S_NUM0     = 18'h02000,
    S_NUM1     = 18'h04000,
    S_FINISH   = 18'h08000,
    S_DRAIN_RD = 18'h10000,
    S_DRAIN_WR = 18'h20000
  } state_t;

  typedef enum logic [5:0] {
    M_CMD   = 6'b000001,
    M_CMD_A = 6'b000010,
    M_AT    = 6'b000100,
    M_DATA  = 6'b001000,
    M_PLUS1 = 6'b010000,
    M_PLUS2 = 6'b100000
  } mode_t;

  typedef enum logic [4:0] {
    P_CMD  = 5'b00001,
    P_NUM  = 5'b00010,
    P_DIAL = 5'b00100,
    P_SREG = 5'b01000,
    P_SVAL = 5'b10000
  } pstate_t;

  typedef enum logic [2:0] {
    C_START = 3'b001,
    C_CMD   = 3'b010,
    C_END   = 3'b100
  } cont_t;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_CONNECT = 3'd1,
    RC_ERROR   = 3'd4
  } rcode_t;

  state_t        state, state_next;
  mode_t         mode, mode_next;
  pstate_t       ps, ps_next;
  cont_t         cont, cont_next;
  rcode_t        rc, rc_next;
  logic [7:0]    name, name_next;
  logic [9:0]    arg1, arg1_next;
  logic [9:0]    arg2, arg2_next;
  logic          echo_on, echo_on_next;
  logic          quiet_on, quiet_on_next;
  logic          verbose_on, verbose_on_next;
  logic          carrier_up, carrier_up_next;
  logic [CW-1:0] idx, idx_next;
  logic [7:0]    pend, pend_next;
  logic [5:0]    rom_ptr, rom_ptr_next;
  logic [5:0]    rom_end, rom_end_next;
  logic          rom_ret, rom_ret_next;

  logic          do_start;
  logic [7:0]    start_c;
  logic [7:0]    c;
  logic          s_bad;
  dec_t          dec;

  assign in_stall = (state != S_IDLE);
  assign c        = st.line_rdata;
  assign s_bad    = ({1'b0, arg1} >= SCNT);
  assign dec      = decimal(st.s_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_CMD;
      ps         <= P_CMD;
      cont       <= C_END;
      rc         <= RC_OK;
      echo_on    <= 1'b1;
      quiet_on   <= 1'b0;
      verbose_on <= 1'b1;
      carrier_up <= 1'b0;
      arg1       <= '0;
      arg2       <= '0;
      rom_ret    <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      ps         <= ps_next;
      cont       <= cont_next;
      rc         <= rc_next;
      echo_on    <= echo_on_next;
      quiet_on   <= quiet_on_next;
      verbose_on <= verbose_on_next;
      carrier_up <= carrier_up_next;
      arg1       <= arg1_next;
      arg2       <= arg2_next;
      rom_ret    <= rom_ret_next;
    end
  end

  always_ff @(posedge clk) begin
    name    <= name_next;
    idx     <= idx_next;
    pend    <= pend_next;
    rom_ptr <= rom_ptr_next;
    rom_end <= rom_end_next;
  end

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    ps_next         = ps;
    cont_next       = cont;
    rc_next         = rc;
    name_next       = name;
    arg1_next       = arg1;
    arg2_next       = arg2;
    echo_on_next    = echo_on;
    quiet_on_next   = quiet_on;
    verbose_on_next = verbose_on;
    carrier_up_next = carrier_up;
    idx_next        = idx;
    pend_next       = pend;
    rom_ptr_next    = rom_ptr;
    rom_end_next    = rom_end;
    rom_ret_next    = rom_ret;
    do_start        = 1'b0;
    start_c         = c;
    cmd             = '0;
    cmd.line_addr   = 8'(idx);
    cmd.s_addr      = arg1[7:0];
    cmd.s_wdata     = arg2[7:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.begin_item = 1'b1;
          state_next     = S_FRONT;
        end
      end

      S_FRONT: begin
        state_next = S_FINISH;
        case (mode)
          M_CMD: begin
            if (st.rx_byte == "A" || st.rx_byte == "a") mode_next = M_CMD_A;
            cmd.emit      = echo_on;
            cmd.emit_byte = st.rx_byte;
          end
          M_CMD_A: begin
            if (st.rx_byte == "T" || st.rx_byte == "t") begin
              mode_next      = M_AT;
              cmd.line_clear = 1'b1;
              rc_next        = RC_OK;
            end else begin
              mode_next = M_CMD;
            end
            cmd.emit      = echo_on;
            cmd.emit_byte = st.rx_byte;
          end
          M_AT: begin
            if (st.rx_byte == CH_CR) begin
              mode_next = M_CMD;
              if (st.line_reject) begin
                cmd.line_clear = 1'b1;
              end else begin
                cmd.emit      = echo_on;
                cmd.emit_byte = CH_CR;
                ps_next       = P_CMD;
                idx_next      = '0;
                state_next    = S_PARSE_RD;
              end
            end else begin
              cmd.line_push = 1'b1;
              cmd.emit      = echo_on;
              cmd.emit_byte = st.rx_byte;
            end
          end
          M_DATA: begin
            if (st.rx_byte == CH_PLUS) begin
              mode_next = M_PLUS1;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_byte = st.rx_byte;
              cmd.emit_port = 1'b1;
            end
          end
          M_PLUS1: begin
            if (st.rx_byte == CH_PLUS) begin
              mode_next = M_PLUS2;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_byte = CH_PLUS;
              cmd.emit_port = 1'b1;
              mode_next     = M_DATA;
              state_next    = S_TAIL_B;
            end
          end
          M_PLUS2: begin
            if (st.rx_byte == CH_PLUS) begin
              mode_next = M_CMD;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_byte = CH_PLUS;
              cmd.emit_port = 1'b1;
              mode_next     = M_DATA;
              state_next    = S_PLUS_B;
            end
          end
          default: begin
            mode_next = M_CMD;
          end
        endcase
      end

      S_PLUS_B: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = CH_PLUS;
        cmd.emit_port = 1'b1;
        state_next    = S_TAIL_B;
      end

      S_TAIL_B: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = st.rx_byte;
        cmd.emit_port = 1'b1;
        state_next    = S_FINISH;
      end

      S_PARSE_RD: begin
        if ((8'(idx) >= st.line_count) || (rc == RC_ERROR)) begin
          if (ps != P_CMD) begin
            cont_next  = C_END;
            state_next = S_EXEC;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          cmd.line_rd = 1'b1;
          state_next  = S_PARSE_EX;
        end
      end

      S_PARSE_EX: begin
        state_next = S_PARSE_RD;
        idx_next   = idx + CW'(1);
        case (ps)
          P_CMD: begin
            if (is_letter(c)) do_start = 1'b1;
            else rc_next = RC_ERROR;
          end
          P_NUM, P_SVAL: begin
            if (is_digit(c)) begin
              if (ps == P_NUM) arg1_next = accumulate(arg1, c);
              else arg2_next = accumulate(arg2, c);
            end else if (is_letter(c)) begin
              idx_next   = idx;
              pend_next  = c;
              cont_next  = C_START;
              state_next = S_EXEC;
            end else begin
              rc_next = RC_ERROR;
            end
          end
          P_DIAL: begin
            if (is_dial(c)) begin
              // skip dial modifiers and digits
            end else if (c == ";") begin
              idx_next   = idx;
              cont_next  = C_CMD;
              state_next = S_EXEC;
            end else begin
              rc_next = RC_ERROR;
            end
          end
          P_SREG: begin
            if (is_digit(c)) begin
              arg1_next = accumulate(arg1, c);
            end else if (c == "=") begin
              name_next = "S";
              arg2_next = '0;
              ps_next   = P_SVAL;
            end else if (c == "?") begin
              idx_next   = idx;
              cont_next  = C_CMD;
              state_next = S_EXEC;
            end else begin
              rc_next = RC_ERROR;
            end
          end
          default: begin
            rc_next = RC_ERROR;
          end
        endcase
      end

      S_EXEC: begin
        state_next = S_CONT;
        case (name)
          "D": begin
            rc_next         = RC_CONNECT;
            mode_next       = M_DATA;
            carrier_up_next = 1'b1;
          end
          "E": begin
            if (arg1 == 10'd0) echo_on_next = 1'b0;
            else if (arg1 == 10'd1) echo_on_next = 1'b1;
            else rc_next = RC_ERROR;
          end
          "Q": begin
            if (arg1 == 10'd0) quiet_on_next = 1'b0;
            else if (arg1 == 10'd1) quiet_on_next = 1'b1;
            else rc_next = RC_ERROR;
          end
          "V": begin
            if (arg1 == 10'd0) verbose_on_next = 1'b0;
            else if (arg1 == 10'd1) verbose_on_next = 1'b1;
            else rc_next = RC_ERROR;
          end
          "H": begin
            carrier_up_next = 1'b0;
          end
          "I": begin
            rc_next      = RC_OK;
            rom_ptr_next = verbose_on ? ROM_I_START : ROM_I_NV_START;
            rom_end_next = ROM_I_END;
            rom_ret_next = 1'b0;
            state_next   = S_ROM;
          end
          "L": begin
            if (arg1 > 10'd3) rc_next = RC_ERROR;
          end
          "M": begin
            if (arg1 > 10'd2) rc_next = RC_ERROR;
          end
          "O": begin
            if (carrier_up) mode_next = M_DATA;
            else rc_next = RC_ERROR;
          end
          "Z": begin
            quiet_on_next   = 1'b0;
            echo_on_next    = 1'b1;
            verbose_on_next = 1'b1;
            carrier_up_next = 1'b0;
            cmd.s_clear     = 1'b1;
          end
          "s": begin
            if (s_bad) begin
              rc_next = RC_ERROR;
            end else begin
              cmd.s_rd   = 1'b1;
              state_next = S_DIG_H;
            end
          end
          "S": begin
            if (s_bad || (arg2 > 10'd255)) rc_next = RC_ERROR;
            else cmd.s_wr = 1'b1;
          end
          default: begin
            rc_next = RC_ERROR;
          end
        endcase
      end

      S_ROM: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = rom_byte(rom_ptr);
        rom_ptr_next  = rom_ptr + 6'd1;
        if (rom_ptr == rom_end) state_next = rom_ret ? S_FINISH : S_CONT;
      end

      S_DIG_H: begin
        cmd.emit      = dec.show_h;
        cmd.emit_byte = CH_ZERO + {4'd0, dec.h};
        state_next    = S_DIG_T;
      end

      S_DIG_T: begin
        cmd.emit      = dec.show_t;
        cmd.emit_byte = CH_ZERO + {4'd0, dec.t};
        state_next    = S_DIG_O;
      end

      S_DIG_O: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = CH_ZERO + {4'd0, dec.o};
        state_next    = S_CONT;
      end

      S_CONT: begin
        case (cont)
          C_START: begin
            do_start   = 1'b1;
            start_c    = pend;
            idx_next   = idx + CW'(1);
            state_next = S_PARSE_RD;
          end
          C_CMD: begin
            ps_next    = P_CMD;
            idx_next   = idx + CW'(1);
            state_next = S_PARSE_RD;
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end

      S_RESULT: begin
        rom_ret_next = 1'b1;
        if (quiet_on) begin
          state_next = S_FINISH;
        end else if (verbose_on) begin
          state_next = S_ROM;
          case (rc)
            RC_OK: begin
              rom_ptr_next = ROM_OK_START;
              rom_end_next = ROM_OK_END;
            end
            RC_CONNECT: begin
              rom_ptr_next = ROM_CON_START;
              rom_end_next = ROM_CON_END;
            end
            default: begin
              rom_ptr_next = ROM_ERR_START;
              rom_end_next = ROM_ERR_END;
            end
          endcase
        end else begin
          state_next = S_NUM0;
        end
      end

      S_NUM0: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = CH_ZERO + {5'd0, rc};
        state_next    = S_NUM1;
      end

      S_NUM1: begin
        cmd.emit      = 1'b1;
        cmd.emit_byte = CH_CR;
        state_next    = S_FINISH;
      end

      S_FINISH: begin
        state_next = st.ob_empty ? S_IDLE : S_DRAIN_RD;
      end

      S_DRAIN_RD: begin
        cmd.drain_rd = 1'b1;
        state_next   = S_DRAIN_WR;
      end

      S_DRAIN_WR: begin
        if (st.out_free) begin
          cmd.drain_load = 1'b1;
          state_next     = st.drain_last ? S_IDLE : S_DRAIN_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // open a new command from a letter
    if (do_start) begin
      if (start_c == "D" || start_c == "d") begin
        name_next = "D";
        ps_next   = P_DIAL;
      end else begin
        arg1_next = '0;
        if (start_c == "S" || start_c == "s") begin
          name_next = "s";
          ps_next   = P_SREG;
        end else begin
          name_next = (start_c >= "a") ? (start_c - 8'd32) : start_c;
          ps_next   = P_NUM;
        end
      end
    end
  end

endmodule

FILE: rtl/at_command_interpreter_unit.sv
// ---------------------------------------------------------------------------
// at_command_interpreter_unit
// Hayes-style AT command interpreter for a byte stream from a terminal.
// ---------------------------------------------------------------------------
// One terminal byte is taken per request; the bytes it causes leave as a burst
// of result requests, the final one flagged by last. In command mode bytes are
// echoed, "AT" opens a line that is buffered up to LINE_DEPTH bytes, and CR
// runs the line's commands and sends the result code (verbose text or a digit,
// nothing when quiet). In data mode bytes go to the link port; a held "+" or
// "++" is released when another byte follows, and "+++" drops back to command
// mode silently. A request that would produce more than MAX_OUT_BYTES bytes
// keeps the first MAX_OUT_BYTES and raises truncated on every byte of its
// burst. Timing: the input is stalled while a request is worked on. An echo
// or data byte, and any extra bytes generated (released "+" signs), are
// written to the response buffer, and every output byte is then drained
// through the registered read of that buffer. A CR scans the line buffer
// byte by byte (registered read of the line memory), generates the response
// bytes of each command (bytes dropped past the limit included) and then
// drains the kept bytes of the response; output stalls hold the drain.
// The last output byte may still wait in the output register while the next
// input byte is accepted. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module at_command_interpreter_unit #(
  parameter int LINE_DEPTH    = 40,
  parameter int S_REG_COUNT   = 13,
  parameter int MAX_OUT_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_port,
  output logic       last,
  output logic       truncated
);
  import atci_pkg::*;

  // Commands from the sequencer and status back from the storage side.
  dp_cmd_t  cmd;
  dp_stat_t st;

  // Sequencer: tracks command/data mode, walks the line on CR and drives
  // every buffer write and the response drain.
  atci_ctrl #(
    .LINE_DEPTH  (LINE_DEPTH),
    .S_REG_COUNT (S_REG_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  // Storage: line buffer, S registers, response buffer, output register.
  atci_dp #(
    .LINE_DEPTH    (LINE_DEPTH),
    .S_REG_COUNT   (S_REG_COUNT),
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_port  (out_port),
    .last      (last),
    .truncated (truncated)
  );

endmodule

FILE: rtl/atci_checker.sv
// ---------------------------------------------------------------------------
// atci_checker
// Port-level checks of the AT interpreter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atci_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last
);

  // An accepted byte keeps the block busy in the next cycle.
  `ASSERT_NEXT(busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accept not held")

  // While a burst is still open no new byte may be taken.
  `ASSERT_SAME(busy_mid_burst, clk, rst, out_valid && !last, in_stall, "input open mid burst")

  // A stalled result holds its byte.
  `ASSERT_NEXT(out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result moved")

endmodule

bind at_command_interpreter_unit atci_checker u_chk (.*);
